[rtl/d2q9_bgk_collision_top_macros.svh]
// Assertion macros shared by the D2Q9 collision block.
`ifndef D2Q9_BGK_COLLISION_TOP_MACROS_SVH
`define D2Q9_BGK_COLLISION_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define D2Q9_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("d2q9 same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define D2Q9_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("d2q9 next-cycle check failed");

`endif

[rtl/d2q9_pkg.sv]
// Types, constants and helpers shared by the D2Q9 collision block.
package d2q9_pkg;

  localparam int NDIR       = 9;
  localparam int WORD_W     = 24;
  localparam int RHO_W      = 28;
  localparam int MOM_W      = 27;
  localparam int CU_W       = 26;
  localparam int POLY_W     = 32;
  localparam int OMEGA_W    = 22;
  localparam int OMEGA_FRAC = 20;
  // Quotient bits kept by the velocity divider; the bits above the word magnitude flag overflow.
  localparam int QBITS      = 26;
  // Magnitude width of the clamped weighted equilibrium before the divide.
  localparam int DIVC_W     = 29;
  // Reciprocal of nine: floor(a / 9) == (a * RECIP_M) >> RECIP_SH for a < 2^29.
  localparam int RECIP_W    = 30;
  localparam int RECIP_SH   = 33;
  localparam logic [RECIP_W-1:0] RECIP_M = 30'd954437177;

  // Pipeline depths of the sub-blocks.
  localparam int DIV_LAT = QBITS + 2;
  localparam int EQ_LAT  = 7;

  localparam logic [OMEGA_W-1:0] RELAX_RESET = 22'd1782579;

  // Lattice directions, y pointing down.
  localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NDIR] = '{0, 0, -1, 0, 1, -1, -1, 1, 1};

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [RHO_W-1:0]  rho_t;
  typedef logic signed [MOM_W-1:0]  mom_t;
  typedef logic signed [CU_W-1:0]   cu_t;
  typedef logic signed [POLY_W-1:0] poly_t;
  typedef logic [OMEGA_W-1:0]       omega_t;

  localparam word_t WORD_MAX = 24'sh7FFFFF;
  localparam word_t WORD_MIN = 24'sh800000;

  typedef struct packed {
    word_t in_dir0;
    word_t in_dir1;
    word_t in_dir2;
    word_t in_dir3;
    word_t in_dir4;
    word_t in_dir5;
    word_t in_dir6;
    word_t in_dir7;
    word_t in_dir8;
    logic  solid;
  } in_item_t;

  typedef struct packed {
    word_t out_dir0;
    word_t out_dir1;
    word_t out_dir2;
    word_t out_dir3;
    word_t out_dir4;
    word_t out_dir5;
    word_t out_dir6;
    word_t out_dir7;
    word_t out_dir8;
    word_t density;
    word_t velocity_x;
    word_t velocity_y;
  } out_item_t;

  // Node data carried alongside the arithmetic.
  typedef struct packed {
    word_t [NDIR-1:0] f;
    logic             solid;
    rho_t             rho;
  } side_t;

  typedef struct packed {
    side_t side;
    word_t ux;
    word_t uy;
  } late_t;

  // Saturate a sign-extended value to the 24-bit word range.
  function automatic word_t sat_word(input logic signed [63:0] v);
    if (v > 64'(WORD_MAX)) begin
      return WORD_MAX;
    end else if (v < 64'(WORD_MIN)) begin
      return WORD_MIN;
    end
    return v[WORD_W-1:0];
  endfunction

endpackage

[rtl/d2q9_delay.sv]
// Enabled delay line that carries node data alongside the arithmetic stages.
module d2q9_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [DEPTH];

  // Shift one place each time the pipeline advances.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

[rtl/d2q9_div.sv]
// Pipelined restoring divider giving both velocity components, one quotient bit a stage.
module d2q9_div #(
  parameter int FRAC_BITS = 20
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  d2q9_pkg::mom_t  mx_i,
  input  d2q9_pkg::mom_t  my_i,
  input  d2q9_pkg::rho_t  rho_i,
  output d2q9_pkg::word_t ux_o,
  output d2q9_pkg::word_t uy_o
);

  localparam int NW = d2q9_pkg::MOM_W - 1 + FRAC_BITS;
  localparam int QB = d2q9_pkg::QBITS;
  localparam int DW = d2q9_pkg::RHO_W - 1;
  localparam int WW = d2q9_pkg::WORD_W;

  logic [NW-1:0]  rem_q [QB+1][2];
  logic [QB-1:0]  quo_q [QB+1][2];
  logic           neg_q [QB+1][2];
  logic [DW-1:0]  dvs_q [QB+1];
  logic           pos_q [QB+1];

  d2q9_pkg::mom_t  mom [2];
  d2q9_pkg::mom_t  mag [2];
  logic            big_p [2];
  logic            big_n [2];
  d2q9_pkg::word_t res_d [2];
  d2q9_pkg::word_t res_q [2];

  // Entry stage: magnitudes of the scaled momenta, signs and the divisor.
  always_comb begin
    mom[0] = mx_i;
    mom[1] = my_i;
    for (int l = 0; l < 2; l++) begin
      mag[l] = mom[l][d2q9_pkg::MOM_W-1] ? -mom[l] : mom[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l] <= {mag[l][d2q9_pkg::MOM_W-2:0], {FRAC_BITS{1'b0}}};
        quo_q[0][l] <= '0;
        neg_q[0][l] <= mom[l][d2q9_pkg::MOM_W-1];
      end
      dvs_q[0] <= rho_i[DW-1:0];
      pos_q[0] <= !rho_i[d2q9_pkg::RHO_W-1] && (rho_i != '0);
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int K = QB - 1 - s;
    logic [NW-1:0] rem_d [2];
    logic          bit_d [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        bit_d[l] = (rem_q[s][l] >> K) >= NW'(dvs_q[s]);
        rem_d[l] = bit_d[l] ? rem_q[s][l] - (NW'(dvs_q[s]) << K) : rem_q[s][l];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 2; l++) begin
          rem_q[s+1][l] <= rem_d[l];
          quo_q[s+1][l] <= {quo_q[s][l][QB-2:0], bit_d[l]};
          neg_q[s+1][l] <= neg_q[s][l];
        end
        dvs_q[s+1] <= dvs_q[s];
        pos_q[s+1] <= pos_q[s];
      end
    end
  end

  // Apply the sign, saturate, and force zero when density is not positive.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      big_p[l] = |quo_q[QB][l][QB-1:WW-1];
      big_n[l] = (|quo_q[QB][l][QB-1:WW]) ||
                 (quo_q[QB][l][WW-1] && (|quo_q[QB][l][WW-2:0]));
      if (!pos_q[QB]) begin
        res_d[l] = '0;
      end else if (neg_q[QB][l]) begin
        res_d[l] = big_n[l] ? d2q9_pkg::WORD_MIN : -quo_q[QB][l][WW-1:0];
      end else begin
        res_d[l] = big_p[l] ? d2q9_pkg::WORD_MAX : quo_q[QB][l][WW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign ux_o = res_q[0];
  assign uy_o = res_q[1];

endmodule

[rtl/d2q9_feq.sv]
// Seven-stage pipeline forming the nine equilibrium distributions.
module d2q9_feq #(
  parameter int FRAC_BITS = 20
) (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  d2q9_pkg::word_t                         ux_i,
  input  d2q9_pkg::word_t                         uy_i,
  input  d2q9_pkg::rho_t                          rho_i,
  output d2q9_pkg::word_t [d2q9_pkg::NDIR-1:0]    feq_o
);

  localparam int ND    = d2q9_pkg::NDIR;
  localparam int WW    = d2q9_pkg::WORD_W;
  localparam int CW    = d2q9_pkg::CU_W;
  localparam int SQ_W  = 2 * CW;
  localparam int USQ_W = 2 * WW;
  localparam int EW    = SQ_W + 4;
  localparam int PW    = d2q9_pkg::POLY_W;
  localparam int PRD_W = d2q9_pkg::RHO_W + PW;
  localparam int XW    = PRD_W + 2;
  localparam int MW    = d2q9_pkg::DIVC_W;
  localparam int RPW   = MW + d2q9_pkg::RECIP_W;
  localparam int QW    = RPW - d2q9_pkg::RECIP_SH;
  localparam logic signed [XW-1:0] LIM = XW'(2 ** MW - 1);
  localparam logic signed [EW-1:0] ONE = EW'(1) <<< FRAC_BITS;
  localparam logic signed [EW-1:0] P_MAX = EW'(2147483647);
  localparam logic signed [EW-1:0] P_MIN = -(EW'(1) <<< 31);

  // Stage 1: projections c.u and the velocity squares.
  d2q9_pkg::cu_t              cu_d  [ND];
  d2q9_pkg::cu_t              cu1_q [ND];
  logic signed [USQ_W-1:0]    ux2_q, uy2_q;
  d2q9_pkg::rho_t             rho1_q;

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      cu_d[d] = '0;
      if (d2q9_pkg::DIR_X[d] == 1) begin
        cu_d[d] = cu_d[d] + CW'(ux_i);
      end else if (d2q9_pkg::DIR_X[d] == -1) begin
        cu_d[d] = cu_d[d] - CW'(ux_i);
      end
      if (d2q9_pkg::DIR_Y[d] == 1) begin
        cu_d[d] = cu_d[d] + CW'(uy_i);
      end else if (d2q9_pkg::DIR_Y[d] == -1) begin
        cu_d[d] = cu_d[d] - CW'(uy_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cu1_q  <= cu_d;
      ux2_q  <= ux_i * ux_i;
      uy2_q  <= uy_i * uy_i;
      rho1_q <= rho_i;
    end
  end

  // Stage 2: floored squares of c.u and of |u|.
  logic signed [SQ_W-1:0] cusq  [ND];
  logic [SQ_W-1:0]        cu2_d [ND];
  logic [SQ_W-1:0]        cu2_q [ND];
  logic [SQ_W-1:0]        usq_d, usq_q;
  d2q9_pkg::cu_t          cu2c_q [ND];
  d2q9_pkg::rho_t         rho2_q;

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      cusq[d]  = cu1_q[d] * cu1_q[d];
      cu2_d[d] = $unsigned(cusq[d]) >> FRAC_BITS;
    end
    usq_d = SQ_W'(({1'b0, ux2_q} + {1'b0, uy2_q}) >> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cu2_q  <= cu2_d;
      usq_q  <= usq_d;
      cu2c_q <= cu1_q;
      rho2_q <= rho1_q;
    end
  end

  // Stage 3: bracket polynomial, clamped to 32 bits.
  logic signed [EW-1:0] u15;
  logic signed [EW-1:0] b9  [ND];
  logic signed [EW-1:0] pw  [ND];
  d2q9_pkg::poly_t      poly_d [ND];
  d2q9_pkg::poly_t      poly_q [ND];
  d2q9_pkg::rho_t       rho3_q;

  always_comb begin
    u15 = ($signed({4'b0, usq_q}) * EW'(3)) >>> 1;
    for (int d = 0; d < ND; d++) begin
      b9[d] = ($signed({4'b0, cu2_q[d]}) * EW'(9)) >>> 1;
      pw[d] = ONE + EW'(cu2c_q[d]) * EW'(3) + b9[d] - u15;
      if (pw[d] > P_MAX) begin
        poly_d[d] = P_MAX[PW-1:0];
      end else if (pw[d] < P_MIN) begin
        poly_d[d] = P_MIN[PW-1:0];
      end else begin
        poly_d[d] = pw[d][PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      poly_q <= poly_d;
      rho3_q <= rho2_q;
    end
  end

  // Stage 4: density times polynomial, floored back to the fraction scale.
  logic signed [PRD_W-1:0] prd   [ND];
  logic signed [PRD_W-1:0] eqa_q [ND];

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      prd[d] = rho3_q * poly_q[d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int d = 0; d < ND; d++) begin
        eqa_q[d] <= prd[d] >>> FRAC_BITS;
      end
    end
  end

  // Stage 5: weight numerator, clamp far past saturation, magnitude and sign.
  logic signed [XW-1:0] xw  [ND];
  logic signed [XW-1:0] cl  [ND];
  logic signed [XW-1:0] ab  [ND];
  logic [MW-1:0]        mag_d [ND];
  logic [MW-1:0]        mag_q [ND];
  logic                 neg5_q [ND];

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      xw[d] = (d == 0) ? (XW'(eqa_q[d]) <<< 2) : XW'(eqa_q[d]);
      if (xw[d] > LIM) begin
        cl[d] = LIM;
      end else if (xw[d] < -LIM) begin
        cl[d] = -LIM;
      end else begin
        cl[d] = xw[d];
      end
      ab[d] = cl[d][XW-1] ? -cl[d] : cl[d];
      // The diagonal weight 1/36 is a divide by four ahead of the divide by nine.
      mag_d[d] = (d >= 5) ? (ab[d][MW-1:0] >> 2) : ab[d][MW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      for (int d = 0; d < ND; d++) begin
        neg5_q[d] <= xw[d][XW-1];
      end
    end
  end

  // Stage 6: divide the magnitude by nine through the reciprocal.
  logic [RPW-1:0] rp    [ND];
  logic [QW-1:0]  quo_q [ND];
  logic           neg6_q [ND];

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      rp[d] = mag_q[d] * d2q9_pkg::RECIP_M;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int d = 0; d < ND; d++) begin
        quo_q[d] <= rp[d][RPW-1:d2q9_pkg::RECIP_SH];
      end
      neg6_q <= neg5_q;
    end
  end

  // Stage 7: restore the sign and saturate to a word.
  d2q9_pkg::word_t feq_d [ND];
  d2q9_pkg::word_t feq_q [ND];

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      if (neg6_q[d]) begin
        if ((|quo_q[d][QW-1:WW]) || (quo_q[d][WW-1] && (|quo_q[d][WW-2:0]))) begin
          feq_d[d] = d2q9_pkg::WORD_MIN;
        end else begin
          feq_d[d] = -quo_q[d][WW-1:0];
        end
      end else begin
        feq_d[d] = (|quo_q[d][QW-1:WW-1]) ? d2q9_pkg::WORD_MAX : quo_q[d][WW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      feq_q <= feq_d;
    end
  end

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      feq_o[d] = feq_q[d];
    end
  end

endmodule

[rtl/d2q9_bgk_collision_top.sv]
// Top level of the D2Q9 BGK collision pipeline for one fluid node per item.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    in_item_i   (nine distributions, solid)
//   out       output     out_valid_o / out_ready_i  out_item_o  (nine, density, velocity)
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i  (omega, unsigned Q2.20)
//
// One item enters per cycle while the output is not held; each item passes the
// sum stage, the 26 quotient-bit stages of the velocity divider, and the
// equilibrium and relaxation stages before it leaves.
// Reset clears every valid bit and loads omega with 1.7.
// When the output item is held, every stage holds and no item is taken.
`include "d2q9_bgk_collision_top_macros.svh"

module d2q9_bgk_collision_top #(
  parameter int FRAC_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  d2q9_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output d2q9_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  d2q9_pkg::omega_t    cfg_data_i
);

  localparam int ND  = d2q9_pkg::NDIR;
  localparam int WW  = d2q9_pkg::WORD_W;
  localparam int RW  = d2q9_pkg::RHO_W;
  localparam int MW  = d2q9_pkg::MOM_W;
  localparam int LAT = 1 + d2q9_pkg::DIV_LAT + d2q9_pkg::EQ_LAT + 2;
  localparam int TW  = WW + 1 + d2q9_pkg::OMEGA_W + 1;

  logic adv;
  logic [LAT-1:0] vld_q;
  d2q9_pkg::omega_t relax_q;

  // The whole pipeline moves unless a finished item waits at the output.
  assign adv         = !out_valid_o || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[LAT-1];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Relaxation factor register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= d2q9_pkg::RELAX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      relax_q <= cfg_data_i;
    end
  end

  // Stage 1: density and both momenta as exact sums.
  d2q9_pkg::word_t f_in [ND];
  d2q9_pkg::rho_t  fe   [ND];
  d2q9_pkg::rho_t  rho_sum;
  d2q9_pkg::mom_t  mx_sum, my_sum;
  d2q9_pkg::side_t side_d, side1_q;
  d2q9_pkg::mom_t  mx1_q, my1_q;

  always_comb begin
    f_in[0] = in_item_i.in_dir0;
    f_in[1] = in_item_i.in_dir1;
    f_in[2] = in_item_i.in_dir2;
    f_in[3] = in_item_i.in_dir3;
    f_in[4] = in_item_i.in_dir4;
    f_in[5] = in_item_i.in_dir5;
    f_in[6] = in_item_i.in_dir6;
    f_in[7] = in_item_i.in_dir7;
    f_in[8] = in_item_i.in_dir8;
    rho_sum = '0;
    mx_sum  = '0;
    my_sum  = '0;
    for (int d = 0; d < ND; d++) begin
      fe[d]   = {{(RW-WW){f_in[d][WW-1]}}, f_in[d]};
      rho_sum = rho_sum + fe[d];
      if (d2q9_pkg::DIR_X[d] == 1) begin
        mx_sum = mx_sum + fe[d][MW-1:0];
      end else if (d2q9_pkg::DIR_X[d] == -1) begin
        mx_sum = mx_sum - fe[d][MW-1:0];
      end
      if (d2q9_pkg::DIR_Y[d] == 1) begin
        my_sum = my_sum + fe[d][MW-1:0];
      end else if (d2q9_pkg::DIR_Y[d] == -1) begin
        my_sum = my_sum - fe[d][MW-1:0];
      end
      side_d.f[d] = f_in[d];
    end
    side_d.solid = in_item_i.solid;
    side_d.rho   = rho_sum;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side1_q <= side_d;
      mx1_q   <= mx_sum;
      my1_q   <= my_sum;
    end
  end

  // Velocity divider and the node data that travels beside it.
  d2q9_pkg::word_t ux_v, uy_v;
  d2q9_pkg::side_t side29;

  d2q9_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .mx_i  (mx1_q),
    .my_i  (my1_q),
    .rho_i (side1_q.rho),
    .ux_o  (ux_v),
    .uy_o  (uy_v)
  );

  d2q9_delay #(.W($bits(d2q9_pkg::side_t)), .DEPTH(d2q9_pkg::DIV_LAT)) u_side_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (side1_q),
    .q_o   (side29)
  );

  // Equilibrium pipeline and the node data that travels beside it.
  d2q9_pkg::word_t [ND-1:0] feq_v;
  d2q9_pkg::late_t late_d, late36;

  d2q9_feq #(.FRAC_BITS(FRAC_BITS)) u_feq (
    .clk_i (clk_i),
    .en_i  (adv),
    .ux_i  (ux_v),
    .uy_i  (uy_v),
    .rho_i (side29.rho),
    .feq_o (feq_v)
  );

  always_comb begin
    late_d.side = side29;
    late_d.ux   = ux_v;
    late_d.uy   = uy_v;
  end

  d2q9_delay #(.W($bits(d2q9_pkg::late_t)), .DEPTH(d2q9_pkg::EQ_LAT)) u_late_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (late_d),
    .q_o   (late36)
  );

  // Relaxation stage: omega times the distance to equilibrium.
  logic signed [WW:0]   df  [ND];
  logic signed [TW-1:0] tm  [ND];
  logic signed [TW-1:0] t_q [ND];
  d2q9_pkg::late_t      late37_q;

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      df[d] = $signed(feq_v[d]) - $signed(late36.side.f[d]);
      tm[d] = df[d] * $signed({1'b0, relax_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q      <= tm;
      late37_q <= late36;
    end
  end

  // Output stage: new distributions, solid pass-through, density and velocity.
  d2q9_pkg::word_t     nv [ND];
  d2q9_pkg::out_item_t out_d, out_q;

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      if (late37_q.side.solid) begin
        nv[d] = late37_q.side.f[d];
      end else begin
        nv[d] = d2q9_pkg::sat_word(64'(t_q[d] >>> d2q9_pkg::OMEGA_FRAC) +
                                   64'($signed(late37_q.side.f[d])));
      end
    end
    out_d.out_dir0 = nv[0];
    out_d.out_dir1 = nv[1];
    out_d.out_dir2 = nv[2];
    out_d.out_dir3 = nv[3];
    out_d.out_dir4 = nv[4];
    out_d.out_dir5 = nv[5];
    out_d.out_dir6 = nv[6];
    out_d.out_dir7 = nv[7];
    out_d.out_dir8 = nv[8];
    if (late37_q.side.solid) begin
      out_d.density    = '0;
      out_d.velocity_x = '0;
      out_d.velocity_y = '0;
    end else begin
      out_d.density    = d2q9_pkg::sat_word(64'(late37_q.side.rho));
      out_d.velocity_x = late37_q.ux;
      out_d.velocity_y = late37_q.uy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

  // Checks on pipeline control and on the result fields.
  `D2Q9_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, vld_q[0])
  `D2Q9_ASSERT_NEXT(a_stall_freezes, !in_ready_o, $stable(vld_q))
  `D2Q9_ASSERT_SAME(a_rho_zero_vel, out_valid_o && ($signed(out_item_o.density) <= 0),
                    (out_item_o.velocity_x == '0) && (out_item_o.velocity_y == '0))

endmodule
